@@ design/wsfp_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Shared parse phase encoding and the result word carried between modules.
// ----------------------------------------------------------------------------
package wsfp_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned OpcodeW = 4;
   localparam int unsigned LenW    = 64;
   localparam int unsigned CountW  = 4;

   localparam logic [6:0] Len7Ext16 = 7'd126;
   localparam logic [6:0] Len7Ext64 = 7'd127;
   localparam logic [CountW-1:0] Ext16Bytes = 4'd2;
   localparam logic [CountW-1:0] Ext64Bytes = 4'd8;
   localparam logic [CountW-1:0] KeyBytes   = 4'd4;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0]   data_byte;
      logic               has_data;
      logic               fin_flag;
      logic [OpcodeW-1:0] frame_opcode;
      logic               masked_flag;
      logic [LenW-1:0]    frame_length;
      logic [LenW-1:0]    byte_offset;
      logic               last_of_frame;
   } result_type;

endpackage

@@ design/wsfp_parse.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame header parser and payload unmasker
// Consumes one frame byte per accepted word and forms the result word, if any.
// ----------------------------------------------------------------------------
module wsfp_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_fire,
   input  logic [wsfp_pkg::ByteW-1:0]  in_byte,
   output logic                        res_valid,
   output wsfp_pkg::result_type        res
);
   import wsfp_pkg::*;

   phase_type           phase_ff, phase_in;
   logic                fin_ff, fin_in;
   logic [OpcodeW-1:0]  opcode_ff, opcode_in;
   logic                mask_ff, mask_in;
   logic [LenW-1:0]     len_ff, len_in;
   logic [CountW-1:0]   cnt_ff, cnt_in;
   logic [LenW-1:0]     pcount_ff, pcount_in;
   logic [ByteW-1:0]    key_ff [4];

   logic [6:0]          len7;
   logic [LenW-1:0]     len_shift;
   logic [CountW-1:0]   cnt_dec;
   logic [CountW-1:0]   cnt_inc;
   logic [LenW-1:0]     pcount_next;
   logic                last_byte;
   logic                emit;
   logic                emit_marker;
   logic                key_we;

   assign len7        = in_byte[6:0];
   assign len_shift   = {len_ff[LenW-ByteW-1:0], in_byte};
   assign cnt_dec     = cnt_ff - 1'b1;
   assign cnt_inc     = cnt_ff + 1'b1;
   assign pcount_next = pcount_ff + 1'b1;
   assign last_byte   = (pcount_next == len_ff);

   // Next phase and header registers.
   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      opcode_in   = opcode_ff;
      mask_in     = mask_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      pcount_in   = pcount_ff;
      emit_marker = 1'b0;
      unique case (phase_ff)
         PH_SECOND: begin
            mask_in = in_byte[7];
            cnt_in  = '0;
            if (len7 == Len7Ext16 || len7 == Len7Ext64) begin
               len_in   = '0;
               cnt_in   = (len7 == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
               phase_in = PH_EXTLEN;
            end else begin
               len_in    = {{(LenW-7){1'b0}}, len7};
               pcount_in = '0;
               if (in_byte[7]) begin
                  phase_in = PH_KEY;
               end else if (len7 == 7'd0) begin
                  phase_in    = PH_FIRST;
                  emit_marker = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_EXTLEN: begin
            len_in = len_shift;
            cnt_in = cnt_dec;
            if (cnt_dec == '0) begin
               pcount_in = '0;
               if (mask_ff) begin
                  phase_in = PH_KEY;
               end else if (len_shift == '0) begin
                  phase_in    = PH_FIRST;
                  emit_marker = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_KEY: begin
            cnt_in = cnt_inc;
            if (cnt_inc >= KeyBytes) begin
               pcount_in = '0;
               if (len_ff == '0) begin
                  phase_in    = PH_FIRST;
                  emit_marker = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            pcount_in = pcount_next;
            if (last_byte) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            fin_in    = in_byte[7];
            opcode_in = in_byte[OpcodeW-1:0];
            phase_in  = PH_SECOND;
         end
      endcase
   end

   // Result word and key capture.
   always_comb begin
      emit   = emit_marker;
      key_we = 1'b0;
      res.data_byte     = '0;
      res.has_data      = 1'b0;
      res.fin_flag      = fin_in;
      res.frame_opcode  = opcode_in;
      res.masked_flag   = mask_in;
      res.frame_length  = len_in;
      res.byte_offset   = '0;
      res.last_of_frame = 1'b1;
      unique case (phase_ff)
         PH_KEY: begin
            key_we = 1'b1;
         end
         PH_PAYLOAD: begin
            emit              = 1'b1;
            res.has_data      = 1'b1;
            res.data_byte     = mask_ff ? (in_byte ^ key_ff[pcount_ff[1:0]]) : in_byte;
            res.byte_offset   = pcount_ff;
            res.last_of_frame = last_byte;
         end
         default: begin
         end
      endcase
   end

   assign res_valid = in_fire && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         pcount_ff <= '0;
      end else if (in_fire) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         pcount_ff <= pcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire && key_we) begin
         key_ff[cnt_ff[1:0]] <= in_byte;
      end
   end

`ifndef ASSERT_OFF
   a_key_needs_mask: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_KEY |-> mask_ff)
      else $error("key phase entered for an unmasked frame");
   a_payload_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> pcount_ff < len_ff)
      else $error("payload offset reached the frame length");
   a_ext_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_EXTLEN |-> cnt_ff != '0 && cnt_ff <= Ext64Bytes)
      else $error("extended length byte count out of range");
`endif

endmodule

@@ design/websocket_frame_parse_unmask.sv @@
// A result reaches rsp_ through the output register, or through the skid entry while the output is stalled.
// Throughput: one frame byte per cycle while the skid entry is empty, set by the single parse stage.
// A two-entry output register with skid keeps req_ready high while one result waits.
// Header bytes produce no result; payload bytes and empty-frame markers produce one.
// Reset is synchronous and returns the parser to expect the first header byte.
// ----------------------------------------------------------------------------
// WebSocket frame parse and unmask, top level
// Parses frame headers from a byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
module websocket_frame_parse_unmask (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wsfp_pkg::ByteW-1:0]    req_frame_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wsfp_pkg::ByteW-1:0]    rsp_data_byte,
   output logic                          rsp_has_data,
   output logic                          rsp_fin_flag,
   output logic [wsfp_pkg::OpcodeW-1:0]  rsp_frame_opcode,
   output logic                          rsp_masked_flag,
   output logic [wsfp_pkg::LenW-1:0]     rsp_frame_length,
   output logic [wsfp_pkg::LenW-1:0]     rsp_byte_offset,
   output logic                          rsp_last_of_frame
);
   import wsfp_pkg::*;

   logic       in_fire;
   logic       res_valid;
   result_type res;
   result_type out_ff, out_in;
   result_type skid_ff;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       out_free;

   assign req_ready = !skid_valid_ff;
   assign in_fire   = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   wsfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_byte   (req_frame_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (!out_free && res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_has_data      = out_ff.has_data;
   assign rsp_fin_flag      = out_ff.fin_flag;
   assign rsp_frame_opcode  = out_ff.frame_opcode;
   assign rsp_masked_flag   = out_ff.masked_flag;
   assign rsp_frame_length  = out_ff.frame_length;
   assign rsp_byte_offset   = out_ff.byte_offset;
   assign rsp_last_of_frame = out_ff.last_of_frame;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while the output register is empty");
   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.has_data |->
         out_ff.last_of_frame && out_ff.data_byte == '0 && out_ff.frame_length == '0)
      else $error("empty-frame marker is malformed");
   a_last_offset: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.has_data && out_ff.last_of_frame |->
         out_ff.byte_offset + 1'b1 == out_ff.frame_length)
      else $error("last payload byte at the wrong offset");
`endif

endmodule

@@ verif/websocket_frame_checker.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame parser result checker
// Watches both channels of the parser and tracks the frame header, length,
// key and payload position from the accepted stream bytes. Each result word
// is compared field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module websocket_frame_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [wsfp_pkg::ByteW-1:0]    req_frame_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [wsfp_pkg::ByteW-1:0]    rsp_data_byte,
   input  logic                          rsp_has_data,
   input  logic                          rsp_fin_flag,
   input  logic [wsfp_pkg::OpcodeW-1:0]  rsp_frame_opcode,
   input  logic                          rsp_masked_flag,
   input  logic [wsfp_pkg::LenW-1:0]     rsp_frame_length,
   input  logic [wsfp_pkg::LenW-1:0]     rsp_byte_offset,
   input  logic                          rsp_last_of_frame,
   output int                            fail_count,
   output int                            pending,
   output int                            payload_words,
   output int                            marker_words
);
   timeunit 1ns;
   timeprecision 1ps;

   import wsfp_pkg::*;

   phase_type           phase;
   logic                held_fin;
   logic [OpcodeW-1:0]  held_opcode;
   logic                held_mask;
   logic [LenW-1:0]     frame_len;
   logic [CountW-1:0]   hdr_count;
   logic [ByteW-1:0]    mask_key [4];
   logic [LenW-1:0]     payload_idx;
   result_type          expected_words [$];

   task automatic push_result(input logic [ByteW-1:0] data, input logic has,
                              input logic [LenW-1:0] offset, input logic last);
      result_type r;
      r.data_byte     = data;
      r.has_data      = has;
      r.fin_flag      = held_fin;
      r.frame_opcode  = held_opcode;
      r.masked_flag   = held_mask;
      r.frame_length  = frame_len;
      r.byte_offset   = offset;
      r.last_of_frame = last;
      expected_words.push_back(r);
   endtask

   task automatic start_payload();
      payload_idx = '0;
      if (frame_len == '0) begin
         phase = PH_FIRST;
         push_result('0, 1'b0, '0, 1'b1);
      end else begin
         phase = PH_PAYLOAD;
      end
   endtask

   task automatic finish_length();
      hdr_count = '0;
      if (held_mask) begin
         phase = PH_KEY;
      end else begin
         start_payload();
      end
   endtask

   task automatic parse_byte(input logic [ByteW-1:0] b);
      logic [ByteW-1:0] plain;
      logic             last;
      case (phase)
         PH_SECOND: begin
            held_mask = b[7];
            hdr_count = '0;
            if (b[6:0] == Len7Ext16 || b[6:0] == Len7Ext64) begin
               frame_len = '0;
               hdr_count = (b[6:0] == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
               phase     = PH_EXTLEN;
            end else begin
               frame_len = LenW'(b[6:0]);
               finish_length();
            end
         end
         PH_EXTLEN: begin
            frame_len = {frame_len[LenW-ByteW-1:0], b};
            hdr_count = hdr_count - 1'b1;
            if (hdr_count == '0) begin
               finish_length();
            end
         end
         PH_KEY: begin
            mask_key[hdr_count[1:0]] = b;
            hdr_count = hdr_count + 1'b1;
            if (hdr_count >= KeyBytes) begin
               start_payload();
            end
         end
         PH_PAYLOAD: begin
            plain = held_mask ? (b ^ mask_key[payload_idx[1:0]]) : b;
            last  = (payload_idx + LenW'(1) == frame_len);
            if (last) begin
               phase = PH_FIRST;
            end
            push_result(plain, 1'b1, payload_idx, last);
            payload_idx = payload_idx + LenW'(1);
         end
         default: begin
            held_fin    = b[7];
            held_opcode = b[3:0];
            phase       = PH_SECOND;
         end
      endcase
   endtask

   task automatic check_field(input string field, input logic [LenW-1:0] got,
                              input logic [LenW-1:0] want);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         phase       = PH_FIRST;
         held_fin    = 1'b0;
         held_opcode = '0;
         held_mask   = 1'b0;
         frame_len   = '0;
         hdr_count   = '0;
         payload_idx = '0;
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_frame_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word, expected none, got data 0x%0h offset %0d",
                        $time, rsp_data_byte, rsp_byte_offset);
            end else begin
               want = expected_words.pop_front();
               check_field("data_byte", LenW'(rsp_data_byte), LenW'(want.data_byte));
               check_field("has_data", LenW'(rsp_has_data), LenW'(want.has_data));
               check_field("fin_flag", LenW'(rsp_fin_flag), LenW'(want.fin_flag));
               check_field("frame_opcode", LenW'(rsp_frame_opcode),
                           LenW'(want.frame_opcode));
               check_field("masked_flag", LenW'(rsp_masked_flag), LenW'(want.masked_flag));
               check_field("frame_length", rsp_frame_length, want.frame_length);
               check_field("byte_offset", rsp_byte_offset, want.byte_offset);
               check_field("last_of_frame", LenW'(rsp_last_of_frame),
                           LenW'(want.last_of_frame));
               if (want.has_data) begin
                  payload_words++;
               end else begin
                  marker_words++;
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame parse and unmask testbench
// Streams directed and random frames (short, 16-bit and 64-bit lengths,
// masked and unmasked, empty frames) through the parser under several
// sender and receiver idling mixes, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsfp_pkg::*;

   localparam int ItemTarget  = 1750;
   localparam int PhaseCount  = 4;
   localparam int QuietLimit  = 2000;
   localparam int HoldCycles  = 200;
   localparam int DrainCycles = 8;

   typedef enum logic [1:0] {
      LEN_SHORT,
      LEN_EXT16,
      LEN_EXT64
   } len_form_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [ByteW-1:0]    req_frame_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [ByteW-1:0]    rsp_data_byte;
   logic                rsp_has_data;
   logic                rsp_fin_flag;
   logic [OpcodeW-1:0]  rsp_frame_opcode;
   logic                rsp_masked_flag;
   logic [LenW-1:0]     rsp_frame_length;
   logic [LenW-1:0]     rsp_byte_offset;
   logic                rsp_last_of_frame;

   int fail_count;
   int pending;
   int payload_words;
   int marker_words;
   int idle_pct;
   int stall_pct;
   bit hold_request;
   int bytes_sent;
   int frames_sent;

   websocket_frame_parse_unmask uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_byte    (req_frame_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_fin_flag      (rsp_fin_flag),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_masked_flag   (rsp_masked_flag),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   websocket_frame_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_byte    (req_frame_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_fin_flag      (rsp_fin_flag),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_masked_flag   (rsp_masked_flag),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_last_of_frame (rsp_last_of_frame),
      .fail_count        (fail_count),
      .pending           (pending),
      .payload_words     (payload_words),
      .marker_words      (marker_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("websocket_frame_parse_unmask test failed");
      $finish;
   end

   task automatic push_byte(input logic [ByteW-1:0] b);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid      <= 1'b1;
      req_frame_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic fin, input logic [OpcodeW-1:0] opcode,
                             input logic masked, input len_form_type form,
                             input logic [LenW-1:0] length, input int payload_bytes);
      logic [31:0] key;
      key = $urandom;
      push_byte({fin, 3'($urandom_range(7)), opcode});
      case (form)
         LEN_EXT16: begin
            push_byte({masked, Len7Ext16});
            push_byte(length[15:8]);
            push_byte(length[7:0]);
         end
         LEN_EXT64: begin
            push_byte({masked, Len7Ext64});
            for (int i = 7; i >= 0; i--) push_byte(length[8*i +: 8]);
         end
         default: begin
            push_byte({masked, length[6:0]});
         end
      endcase
      if (masked) begin
         for (int i = 0; i < 4; i++) push_byte(key[8*i +: 8]);
      end
      for (int i = 0; i < payload_bytes; i++) push_byte(8'($urandom));
      frames_sent++;
   endtask

   initial begin : stimulus
      logic [LenW-1:0] length;
      len_form_type    form;
      int              pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_frame_byte = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      hold_request   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_frame(1'b1, 4'hF, 1'b0, LEN_SHORT, 64'd0, 0);
      send_frame(1'b0, 4'h0, 1'b1, LEN_SHORT, 64'd1, 1);
      send_frame(1'b1, 4'h8, 1'b0, LEN_EXT16, 64'd1, 1);
      send_frame(1'b0, 4'h2, 1'b1, LEN_EXT64, 64'd0, 0);

      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         if (p == 0) begin
            // The receiver stops for a long stretch while a long frame streams in.
            hold_request = 1'b1;
            send_frame(1'b1, 4'h1, 1'b0, LEN_SHORT, 64'd64, 64);
         end
         if (p == PhaseCount - 1) begin
            send_frame(1'b0, 4'h9, 1'b1, LEN_SHORT, 64'd125, 125);
         end
         while (bytes_sent < (p + 1) * ItemTarget / PhaseCount) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               form   = LEN_SHORT;
               length = ($urandom_range(9) == 0) ? LenW'($urandom_range(125))
                                                 : LenW'($urandom_range(12));
            end else if (pick < 80) begin
               form   = LEN_EXT16;
               length = ($urandom_range(19) == 0) ? LenW'($urandom_range(400, 126))
                                                  : LenW'($urandom_range(20));
            end else begin
               form   = LEN_EXT64;
               length = LenW'($urandom_range(16));
            end
            send_frame(1'($urandom_range(1)), 4'($urandom), ($urandom_range(99) < 60),
                       form, length, int'(length));
         end
      end

      // A frame with the largest 64-bit length never completes; only its first bytes go in.
      send_frame(1'b1, 4'h2, 1'b1, LEN_EXT64, '1, 24);
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d stream bytes in %0d frames across four idling mixes and a hold-off.",
               bytes_sent, frames_sent);
      $display("Checked %0d payload words and %0d empty-frame markers.",
               payload_words, marker_words);
      if (fail_count == 0) begin
         $display("websocket_frame_parse_unmask test passed");
      end else begin
         $display("websocket_frame_parse_unmask test failed");
      end
      $finish;
   end

endmodule

@@ websocket_frame_parse_unmask.f @@
design/wsfp_pkg.sv
design/wsfp_parse.sv
design/websocket_frame_parse_unmask.sv
verif/websocket_frame_checker.sv
verif/tb.sv
